/* sv/lc3b_pkg.sv */
package lc3b_pkg;

  localparam int MemWords  = 32768;
  localparam int MemAw     = $clog2(MemWords);
  localparam int CsRows    = 64;
  localparam int CsAw      = $clog2(CsRows);
  localparam int CsWidth   = 35;
  localparam logic [5:0] StartState = 6'd18;
  localparam logic [3:0] LatencyReset = 4'd5;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CS_LOAD = 2'd1,
    MODE_MEM_LOAD = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_MEMRD = 5'b01000,
    ST_OUT   = 5'b10000
  } seq_t;

  // Control word bit position for microcode signal j (j=0 is IRD).
  function automatic logic cw_bit(input logic [CsWidth-1:0] w, input int j);
    return w[CsWidth-1-j];
  endfunction

  function automatic logic [1:0] cw_bits2(input logic [CsWidth-1:0] w, input int j);
    return {w[CsWidth-1-j], w[CsWidth-2-j]};
  endfunction

  function automatic logic [15:0] sext16(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits-1];
    end
    return r;
  endfunction

  function automatic logic [3:0] eff_lat(input logic [3:0] l);
    return (l < 4'd2) ? 4'd2 : l;
  endfunction

endpackage

/* sv/lc3b_main_mem.sv */
module lc3b_main_mem
  import lc3b_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [MemAw-1:0] waddr,
  input  logic [15:0]      wdata,
  input  logic [MemAw-1:0] raddr,
  output logic [15:0]      rdata
);

  logic [15:0] mem [MemWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lc3b_ctrl_store.sv */
module lc3b_ctrl_store
  import lc3b_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [CsAw-1:0]    waddr,
  input  logic [CsWidth-1:0] wdata,
  input  logic [CsAw-1:0]    raddr,
  output logic [CsWidth-1:0] rdata
);

  logic [CsWidth-1:0] mem [CsRows];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lc3b_microcoded_cpu_cycle.sv */
// LC-3b microprogrammed core, one machine clock per tick item. The control
// store row and then the main memory word are read from synchronous memories.
// A load item (control row or memory word), a restart item and a tick while
// halted go from ST_FETCH to ST_OUT. A running tick goes from ST_FETCH through
// ST_EXEC, and also through ST_MEMRD when its memory access completes a read,
// to ST_OUT. After the result is taken the block returns to ST_IDLE before it
// takes the next item. Main memory (32768 words) is cleared after reset by a
// sweep of one word per cycle, during which no item is accepted. Configuration
// writes of mem_latency are to be made only while the block is idle; the block
// itself does not enforce this. They also reload the access countdown. Results
// sit in an output register, and the next item is not taken until that result
// has been delivered.
module lc3b_microcoded_cpu_cycle
  import lc3b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [14:0] in_index,
  input  logic [34:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pc_value,
  output logic [15:0] out_bus_value,
  output logic [15:0] out_ir_value,
  output logic [5:0]  out_micro_state,
  output logic [2:0]  out_cc_nzp,
  output logic        out_mem_ready,
  output logic        out_halted
);

  seq_t seq_r, seq_nxt;

  // Clearing sweep over main memory after reset.
  logic             clr_r;
  logic [MemAw:0]   clr_cnt_r;

  // Architectural state.
  logic [15:0] pc_r, ir_r, mar_r, mdr_r, hold_r, bus_r;
  logic [15:0] regs_r [8];
  logic [2:0]  nzp_r;
  logic        ben_r, rdy_r;
  logic [5:0]  state_r;
  logic [3:0]  cnt_r, lat_r;
  logic [CsWidth-1:0] cw_r;

  logic [1:0]  mode_r;
  logic [14:0] idx_r;
  logic [34:0] data_r;

  // Address of the completing read, kept across a MAR load in the same tick.
  logic [15:0] mar_old_r;
  logic        word_in_r;

  // Memory ports.
  logic               cs_we;
  logic [CsWidth-1:0] cs_rdata;
  logic               mm_we;
  logic [MemAw-1:0]   mm_waddr, mm_raddr;
  logic [15:0]        mm_wdata, mm_rdata;

  logic accept;
  assign in_stall = clr_r || (seq_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_valid = (seq_r == ST_OUT);

  lc3b_ctrl_store u_cs (
    .clk   (clk),
    .we    (cs_we),
    .waddr (idx_r[CsAw-1:0]),
    .wdata (data_r),
    .raddr (state_r),
    .rdata (cs_rdata)
  );

  lc3b_main_mem u_mem (
    .clk   (clk),
    .we    (mm_we),
    .waddr (mm_waddr),
    .wdata (mm_wdata),
    .raddr (mm_raddr),
    .rdata (mm_rdata)
  );

  // Datapath for the tick, evaluated from the registered control word.
  logic [15:0] sr1, sr2, a1v, a2v, adder, marmux, alu, shf, mdrv, bus_v;
  logic [15:0] new_pc;
  logic [5:0]  next_st;
  logic [1:0]  cond;
  logic [2:0]  gates;
  logic [3:0]  cnt_dec;
  logic        mem_go, mem_fin, word_in;
  logic [15:0] word_addr;

  always_comb begin
    cond = cw_bits2(cw_r, 1);
    if (cw_bit(cw_r, 0)) begin
      next_st = {2'b00, ir_r[15:12]};
    end else begin
      next_st = cw_r[CsWidth-4 -: 6];
      case (cond)
        2'd1: next_st[1] = next_st[1] | rdy_r;
        2'd2: next_st[2] = next_st[2] | ben_r;
        2'd3: next_st[0] = next_st[0] | ir_r[11];
        default: ;
      endcase
    end

    mem_go  = (cond == 2'd1);
    cnt_dec = cnt_r - 4'd1;
    mem_fin = mem_go && (cnt_dec == 4'd0);
    word_addr = {1'b0, mar_r[15:1]};
    word_in = (word_addr < 16'(MemWords));

    case (cw_bits2(cw_r, 26))
      2'd0: a2v = '0;
      2'd1: a2v = sext16(ir_r, 6);
      2'd2: a2v = sext16(ir_r, 9);
      default: a2v = sext16(ir_r, 11);
    endcase
    if (cw_bit(cw_r, 34)) a2v = {a2v[14:0], 1'b0};
    sr1 = regs_r[cw_bit(cw_r, 24) ? ir_r[8:6] : ir_r[11:9]];
    a1v = cw_bit(cw_r, 25) ? sr1 : pc_r;
    adder = a1v + a2v;
    marmux = cw_bit(cw_r, 28) ? adder : {7'd0, ir_r[7:0], 1'b0};

    sr2 = ir_r[5] ? sext16(ir_r, 5) : regs_r[ir_r[2:0]];
    case (cw_bits2(cw_r, 29))
      2'd0: alu = sr1 + sr2;
      2'd1: alu = sr1 & sr2;
      2'd2: alu = sr1 ^ sr2;
      default: alu = sr1;
    endcase

    if (!ir_r[4]) shf = sr1 << ir_r[3:0];
    else if (!ir_r[5]) shf = sr1 >> ir_r[3:0];
    else shf = 16'($signed(sr1) >>> ir_r[3:0]);

    mdrv = cw_bit(cw_r, 33) ? mdr_r : sext16(mdr_r, 8);

    gates = 3'(cw_bit(cw_r, 16)) + 3'(cw_bit(cw_r, 17)) + 3'(cw_bit(cw_r, 18))
          + 3'(cw_bit(cw_r, 19)) + 3'(cw_bit(cw_r, 20));
    if (gates == 3'd0) bus_v = '0;
    else if (gates == 3'd1) begin
      if (cw_bit(cw_r, 17)) bus_v = mdrv;
      else if (cw_bit(cw_r, 20)) bus_v = shf;
      else if (cw_bit(cw_r, 16)) bus_v = pc_r;
      else if (cw_bit(cw_r, 19)) bus_v = marmux;
      else bus_v = alu;
    end else bus_v = bus_r;

    new_pc = pc_r;
    if (cw_bit(cw_r, 15)) begin
      case (cw_bits2(cw_r, 21))
        2'd0: new_pc = pc_r + 16'd2;
        2'd1: new_pc = bus_v;
        2'd2: new_pc = adder;
        default: new_pc = pc_r;
      endcase
    end
  end

  // Memory write sources: sweep, load item, or the store of a tick. A byte
  // store merges with the word read in the fetch step.
  logic [15:0] st_word;
  always_comb begin
    st_word = mdr_r;
    if (!cw_bit(cw_r, 33)) begin
      st_word = mar_r[0] ? {mdr_r[7:0], mm_rdata[7:0]} : {mm_rdata[15:8], mdr_r[7:0]};
    end
    mm_raddr = mar_r[MemAw:1];
    cs_we    = (seq_r == ST_FETCH) && (mode_r == MODE_CS_LOAD) && (idx_r < 15'(CsRows));
    mm_we    = 1'b0;
    mm_waddr = idx_r[MemAw-1:0];
    mm_wdata = data_r[15:0];
    if (clr_r) begin
      mm_we    = 1'b1;
      mm_waddr = clr_cnt_r[MemAw-1:0];
      mm_wdata = '0;
    end else if ((seq_r == ST_FETCH) && (mode_r == MODE_MEM_LOAD)) begin
      mm_we = ({1'b0, idx_r} < 16'(MemWords));
    end else if ((seq_r == ST_EXEC) && mem_fin && cw_bit(cw_r, 32) && word_in) begin
      mm_we    = 1'b1;
      mm_waddr = mar_r[MemAw:1];
      mm_wdata = st_word;
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      ST_IDLE:  if (accept) seq_nxt = ST_FETCH;
      ST_FETCH: seq_nxt = ((mode_r == MODE_TICK) && (pc_r != 16'd0)) ? ST_EXEC : ST_OUT;
      ST_EXEC:  seq_nxt = (mem_fin && !cw_bit(cw_r, 32)) ? ST_MEMRD : ST_OUT;
      ST_MEMRD: seq_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) seq_nxt = ST_IDLE;
      default:  seq_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= ST_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      pc_r <= '0; ir_r <= '0; mar_r <= '0; mdr_r <= '0; hold_r <= '0; bus_r <= '0;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
      nzp_r   <= 3'b010;
      ben_r   <= 1'b0;
      rdy_r   <= 1'b0;
      state_r <= StartState;
      lat_r   <= LatencyReset;
      cnt_r   <= LatencyReset;
    end else begin
      seq_r <= seq_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (MemAw+1)'(MemWords - 1)) clr_r <= 1'b0;
      end
      if (cfg_we) begin
        lat_r <= cfg_wdata;
        cnt_r <= eff_lat(cfg_wdata);
      end
      if (accept) begin
        mode_r <= in_mode;
        idx_r  <= in_index;
        data_r <= in_data;
      end
      // The control row for the current microstate is valid in ST_FETCH.
      if (seq_r == ST_FETCH) begin
        cw_r <= cs_rdata;
        if (mode_r == MODE_RESTART) begin
          pc_r    <= data_r[15:0];
          state_r <= StartState;
          nzp_r   <= 3'b010;
        end
      end
      if (seq_r == ST_EXEC) begin
        if (mem_go) begin
          if (mem_fin) begin
            cnt_r <= eff_lat(lat_r);
            rdy_r <= 1'b0;
          end else begin
            cnt_r <= cnt_dec;
            if (cnt_dec == 4'd1) rdy_r <= 1'b1;
          end
        end
        bus_r <= bus_v;
        if (cw_bit(cw_r, 12)) begin
          ben_r <= (nzp_r[2] & ir_r[11]) | (nzp_r[1] & ir_r[10]) | (nzp_r[0] & ir_r[9]);
        end
        if (cw_bit(cw_r, 13)) regs_r[cw_bit(cw_r, 23) ? 3'd7 : ir_r[11:9]] <= bus_v;
        if (cw_bit(cw_r, 14)) begin
          nzp_r <= bus_v[15] ? 3'b100 : ((bus_v == 16'd0) ? 3'b010 : 3'b001);
        end
        if (cw_bit(cw_r, 9)) mar_r <= bus_v;
        // MDR load from memory happens after the read completes, in ST_MEMRD.
        if (cw_bit(cw_r, 10) && !(cw_bit(cw_r, 31) && mem_fin && !cw_bit(cw_r, 32))) begin
          if (cw_bit(cw_r, 31)) mdr_r <= hold_r;
          else mdr_r <= cw_bit(cw_r, 33) ? bus_v : sext16(bus_v, 8);
        end
        if (cw_bit(cw_r, 11)) ir_r <= bus_v;
        pc_r    <= new_pc;
        state_r <= next_st;
      end
      if (seq_r == ST_MEMRD) begin
        // mm_rdata holds the word at the old MAR, read during ST_EXEC.
        logic [15:0] w;
        w = word_in_r ? mm_rdata : 16'd0;
        if (!cw_bit(cw_r, 33)) w = mar_old_r[0] ? {8'd0, w[15:8]} : {8'd0, w[7:0]};
        hold_r <= w;
        if (cw_bit(cw_r, 10) && cw_bit(cw_r, 31)) mdr_r <= w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_r == ST_EXEC) begin
      mar_old_r <= mar_r;
      word_in_r <= word_in;
    end
  end

  // The read in ST_EXEC used mm_raddr from the pre-tick MAR; rdata arrives
  // in ST_MEMRD. For stores, the merge word was read during ST_FETCH.

  assign out_pc_value    = pc_r;
  assign out_bus_value   = bus_r;
  assign out_ir_value    = ir_r;
  assign out_micro_state = state_r;
  assign out_cc_nzp      = nzp_r;
  assign out_mem_ready   = rdy_r;
  assign out_halted      = (pc_r == 16'd0);

endmodule

/* dv/tb_lc3b_microcoded_cpu_cycle.sv */
`timescale 1ns / 100ps

// One observed result of the core: the visible machine state after an item.
typedef struct packed {
  logic [15:0] pc;
  logic [15:0] bus;
  logic [15:0] ir;
  logic [5:0]  ustate;
  logic [2:0]  nzp;
  logic        ready;
  logic        halted;
} cpu_view_t;

// Keeps the expected machine views in order and compares delivered ones.
class cpu_view_board;
  cpu_view_t pending[$];
  int        errors;

  function void note_item(cpu_view_t v);
    pending.push_back(v);
  endfunction

  function void check_view(cpu_view_t got);
    cpu_view_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result pc=%h", $realtime, got.pc);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.pc !== want.pc) begin
      $display("%0t: pc expected %h actual %h", $realtime, want.pc, got.pc);
      errors++;
    end
    if (got.bus !== want.bus) begin
      $display("%0t: bus expected %h actual %h", $realtime, want.bus, got.bus);
      errors++;
    end
    if (got.ir !== want.ir) begin
      $display("%0t: ir expected %h actual %h", $realtime, want.ir, got.ir);
      errors++;
    end
    if (got.ustate !== want.ustate) begin
      $display("%0t: ustate expected %0d actual %0d", $realtime, want.ustate, got.ustate);
      errors++;
    end
    if (got.nzp !== want.nzp) begin
      $display("%0t: nzp expected %b actual %b", $realtime, want.nzp, got.nzp);
      errors++;
    end
    if (got.ready !== want.ready) begin
      $display("%0t: ready expected %b actual %b", $realtime, want.ready, got.ready);
      errors++;
    end
    if (got.halted !== want.halted) begin
      $display("%0t: halted expected %b actual %b", $realtime, want.halted, got.halted);
      errors++;
    end
  endfunction
endclass

module tb_lc3b_microcoded_cpu_cycle;
  import lc3b_pkg::*;

  // The watchdog must cover the clearing sweep of main memory after reset,
  // plus the longest stall and the slowest tick, several times over.
  localparam int WatchdogLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_TICK;
  logic [14:0] in_index = '0;
  logic [34:0] in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pc_value, out_bus_value, out_ir_value;
  logic [5:0]  out_micro_state;
  logic [2:0]  out_cc_nzp;
  logic        out_mem_ready, out_halted;

  lc3b_microcoded_cpu_cycle dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_index(in_index), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pc_value(out_pc_value), .out_bus_value(out_bus_value),
    .out_ir_value(out_ir_value), .out_micro_state(out_micro_state),
    .out_cc_nzp(out_cc_nzp), .out_mem_ready(out_mem_ready),
    .out_halted(out_halted)
  );

  always #10 clk = ~clk;

  cpu_view_board board = new();

  // Shadow copy of the machine, updated as each item is accepted.
  logic [34:0] ucode_rows [CsRows];
  logic [15:0] memory_image [MemWords];
  logic [15:0] gpr [8];
  logic [15:0] pc_q, ir_q, mar_q, mdr_q, fetched_q, bus_q;
  logic [2:0]  nzp_q;
  logic        ben_q, ready_q;
  logic [5:0]  ustate_q;
  logic [3:0]  latency_q, countdown_q;
  logic        row_loaded [CsRows];

  int  idle_cycles;
  bit  sender_done;

  // Control signal j, counted from IRD at the top of the word.
  function automatic logic cs1(logic [34:0] w, int j);
    return w[34 - j];
  endfunction

  function automatic logic [1:0] cs2(logic [34:0] w, int j);
    return {w[34 - j], w[33 - j]};
  endfunction

  function automatic logic [15:0] sign_ext(logic [15:0] v, int bits);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = (i < bits) ? v[i] : v[bits - 1];
    return r;
  endfunction

  function automatic logic [3:0] access_ticks(logic [3:0] l);
    return (l < 4'd2) ? 4'd2 : l;
  endfunction

  function automatic void predict_reset();
    foreach (memory_image[i]) memory_image[i] = '0;
    foreach (ucode_rows[i]) begin
      ucode_rows[i] = '0;
      row_loaded[i] = 1'b0;
    end
    foreach (gpr[i]) gpr[i] = '0;
    pc_q = '0; ir_q = '0; mar_q = '0; mdr_q = '0; fetched_q = '0; bus_q = '0;
    nzp_q = 3'b010; ben_q = 1'b0; ready_q = 1'b0; ustate_q = StartState;
    latency_q = LatencyReset; countdown_q = LatencyReset;
  endfunction

  // Memory side of a tick: countdown, then the access itself at zero.
  function automatic void advance_memory(logic [34:0] w);
    logic [15:0] word;
    logic [15:0] rd;
    word = {1'b0, mar_q[15:1]};
    countdown_q = countdown_q - 4'd1;
    if (countdown_q == 4'd1) begin
      ready_q = 1'b1;
    end else if (countdown_q == 4'd0) begin
      if (cs1(w, 32)) begin
        if (!cs1(w, 33)) begin
          if (mar_q[0]) memory_image[word[14:0]][15:8] = mdr_q[7:0];
          else memory_image[word[14:0]][7:0] = mdr_q[7:0];
        end else begin
          memory_image[word[14:0]] = mdr_q;
        end
      end else begin
        rd = memory_image[word[14:0]];
        if (!cs1(w, 33)) fetched_q = mar_q[0] ? {8'h00, rd[15:8]} : {8'h00, rd[7:0]};
        else fetched_q = rd;
      end
      countdown_q = access_ticks(latency_q);
      ready_q = 1'b0;
    end
  endfunction

  // One machine clock, as the microword at the current state dictates.
  function automatic void machine_clock();
    logic [34:0] w;
    logic [5:0]  nxt;
    logic [15:0] a2v, a1v, sr1, sr2, adder, marmux, alu, shf, mdrv, npc;
    logic [31:0] wide;
    int          gates;
    logic        rdy;
    w = ucode_rows[ustate_q];
    rdy = ready_q;
    npc = pc_q;
    if (cs1(w, 0)) begin
      nxt = {2'b00, ir_q[15:12]};
    end else begin
      nxt = w[31:26];
      case (cs2(w, 1))
        2'd1: nxt[1] = nxt[1] | rdy;
        2'd2: nxt[2] = nxt[2] | ben_q;
        2'd3: nxt[0] = nxt[0] | ir_q[11];
        default: ;
      endcase
    end
    if (cs2(w, 1) == 2'd1) advance_memory(w);

    case (cs2(w, 26))
      2'd0: a2v = '0;
      2'd1: a2v = sign_ext(ir_q, 6);
      2'd2: a2v = sign_ext(ir_q, 9);
      default: a2v = sign_ext(ir_q, 11);
    endcase
    if (cs1(w, 34)) a2v = a2v << 1;
    sr1 = gpr[cs1(w, 24) ? ir_q[8:6] : ir_q[11:9]];
    a1v = cs1(w, 25) ? sr1 : pc_q;
    adder = a1v + a2v;
    marmux = cs1(w, 28) ? adder : {7'd0, ir_q[7:0], 1'b0};
    sr2 = ir_q[5] ? sign_ext(ir_q, 5) : gpr[ir_q[2:0]];
    case (cs2(w, 29))
      2'd0: alu = sr1 + sr2;
      2'd1: alu = sr1 & sr2;
      2'd2: alu = sr1 ^ sr2;
      default: alu = sr1;
    endcase
    if (!ir_q[4]) shf = sr1 << ir_q[3:0];
    else if (!ir_q[5]) shf = sr1 >> ir_q[3:0];
    else begin
      wide = {{16{sr1[15]}}, sr1} >> ir_q[3:0];
      shf = wide[15:0];
    end
    mdrv = cs1(w, 33) ? mdr_q : sign_ext(mdr_q, 8);

    // More than one gate on leaves the bus at its previous value.
    gates = cs1(w, 16) + cs1(w, 17) + cs1(w, 18) + cs1(w, 19) + cs1(w, 20);
    if (gates == 0) bus_q = '0;
    else if (gates == 1) begin
      if (cs1(w, 17)) bus_q = mdrv;
      else if (cs1(w, 20)) bus_q = shf;
      else if (cs1(w, 16)) bus_q = pc_q;
      else if (cs1(w, 19)) bus_q = marmux;
      else bus_q = alu;
    end

    if (cs1(w, 15)) begin
      case (cs2(w, 21))
        2'd0: npc = pc_q + 16'd2;
        2'd1: npc = bus_q;
        2'd2: npc = adder;
        default: ;
      endcase
    end
    if (cs1(w, 12)) ben_q = (nzp_q[2] & ir_q[11]) | (nzp_q[1] & ir_q[10]) | (nzp_q[0] & ir_q[9]);
    if (cs1(w, 13)) gpr[cs1(w, 23) ? 3'd7 : ir_q[11:9]] = bus_q;
    if (cs1(w, 14)) nzp_q = bus_q[15] ? 3'b100 : (bus_q == 0 ? 3'b010 : 3'b001);
    if (cs1(w, 9)) mar_q = bus_q;
    if (cs1(w, 10)) begin
      if (cs1(w, 31)) mdr_q = fetched_q;
      else mdr_q = cs1(w, 33) ? bus_q : sign_ext(bus_q, 8);
    end
    if (cs1(w, 11)) ir_q = bus_q;
    pc_q = npc;
    ustate_q = nxt;
  endfunction

  function automatic cpu_view_t predict_item(logic [1:0] mode, logic [14:0] idx,
                                             logic [34:0] data);
    cpu_view_t v;
    case (mode)
      MODE_TICK: if (pc_q != 0) machine_clock();
      MODE_CS_LOAD: if (idx < CsRows) begin
        ucode_rows[idx[5:0]] = data;
        row_loaded[idx[5:0]] = 1'b1;
      end
      MODE_MEM_LOAD: memory_image[idx] = data[15:0];
      default: begin
        pc_q = data[15:0];
        ustate_q = StartState;
        nzp_q = 3'b010;
      end
    endcase
    v.pc = pc_q; v.bus = bus_q; v.ir = ir_q; v.ustate = ustate_q;
    v.nzp = nzp_q; v.ready = ready_q; v.halted = (pc_q == 0);
    return v;
  endfunction

  // Drive one item and wait for it to be taken; the shadow model is updated
  // at the accepting edge. Valid stays high when the next item follows with
  // no idle cycles; wait_drained takes it low.
  task automatic send_item(logic [1:0] mode, logic [14:0] idx, logic [34:0] data);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode <= mode; in_index <= idx; in_data <= data; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(predict_item(mode, idx, data));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_latency(logic [3:0] l);
    wait_drained();
    cfg_wdata <= l; cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    latency_q = l;
    countdown_q = access_ticks(l);
  endtask

  // A tick only happens from a loaded microstate; otherwise restart first.
  task automatic safe_tick();
    if (pc_q != 0 && !row_loaded[ustate_q])
      send_item(MODE_RESTART, '0, {19'd0, 16'h3000});
    send_item(MODE_TICK, 15'($urandom()), 35'({$urandom(), $urandom()}));
  endtask

  // A random microprogram: every row loaded, next states random, with a
  // bias toward single gates so that values actually reach the bus.
  task automatic load_random_ucode();
    logic [34:0] w;
    for (int r = 0; r < CsRows; r++) begin
      w = 35'({$urandom(), $urandom()});
      if ($urandom_range(0, 2) != 0) begin
        w[18:14] = 5'b00001 << $urandom_range(0, 4);
      end
      if ($urandom_range(0, 3) == 0) w[34] = 1'b1;
      send_item(MODE_CS_LOAD, r[14:0], w);
    end
  endtask

  // Output side: random stalls, with stretches of none.
  initial begin
    int s;
    forever begin
      @(negedge clk);
      s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (s != 0) begin
        out_stall <= 1'b1;
        repeat (s) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_view({out_pc_value, out_bus_value, out_ir_value, out_micro_state,
                        out_cc_nzp, out_mem_ready, out_halted});
  end

  // Watchdog: cycles without any accepted item on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [34:0] w;
    idle_cycles = 0;
    predict_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: a minimal fetch loop, extremes of fields, special cases.
    send_item(MODE_TICK, '0, '0);                      // halted at PC zero
    send_item(MODE_CS_LOAD, 15'h7FFF, {35{1'b1}});     // row out of range
    send_item(MODE_MEM_LOAD, 15'h7FFF, {35{1'b1}});
    send_item(MODE_MEM_LOAD, 15'h1800, {19'h7FFFF, 16'h1234});
    send_item(MODE_MEM_LOAD, 15'h0000, '0);
    // Row 18: MAR <- PC, PC <- PC+2, go to 33.
    w = '0; w[31:26] = 6'd33; w[25] = 1; w[19] = 1; w[18] = 1;
    send_item(MODE_CS_LOAD, 15'd18, w);
    // Row 33: wait on ready with a word read into MDR, loop while not ready.
    w = '0; w[33:32] = 2'd1; w[31:26] = 6'd33; w[24] = 1; w[3] = 1; w[1] = 1;
    send_item(MODE_CS_LOAD, 15'd33, w);
    send_item(MODE_CS_LOAD, 15'd35, w);
    // Row 35 replaced: IR <- MDR, then decode on IR.
    w = '0; w[34] = 1; w[23] = 1; w[17] = 1; w[1] = 1;
    send_item(MODE_CS_LOAD, 15'd35, w);
    for (int r = 0; r < 16; r++) begin
      w = '0; w[31:26] = 6'd18; w[18] = 1; w[17] = 1; // contention holds bus
      send_item(MODE_CS_LOAD, r[14:0], w);
    end
    send_item(MODE_RESTART, '0, {19'h7FFFF, 16'h3000});
    repeat (12) safe_tick();

    // Pause until every result is in, then walk the latency extremes.
    write_latency(4'd0);
    repeat (10) safe_tick();
    write_latency(4'd15);
    load_random_ucode();
    send_item(MODE_RESTART, '0, {19'd0, 16'hFFFF});

    for (int n = 0; n < 620; n++) begin
      if (n % 200 == 199) write_latency(4'($urandom_range(1, 15)));
      case ($urandom_range(0, 19))
        0: send_item(MODE_MEM_LOAD, 15'($urandom()), 35'({$urandom(), $urandom()}));
        1: send_item(MODE_RESTART, 15'($urandom()), 35'({$urandom(), $urandom()}));
        2: begin
          w = 35'({$urandom(), $urandom()});
          send_item(MODE_CS_LOAD, 15'($urandom_range(0, 127)), w);
        end
        3: send_item(MODE_RESTART, '0, '0);
        default: safe_tick();
      endcase
      if (n == 300) load_random_ucode();
    end
    write_latency(4'd2);

    wait_drained();
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* lc3b_microcoded_cpu_cycle.f */
sv/lc3b_pkg.sv
sv/lc3b_main_mem.sv
sv/lc3b_ctrl_store.sv
sv/lc3b_microcoded_cpu_cycle.sv
dv/tb_lc3b_microcoded_cpu_cycle.sv
